// ===== sv/text_line_fit_truncate_wrap_unit_macros.svh =====
// Assertion macros shared by the line fitting unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TEXT_LINE_FIT_TRUNCATE_WRAP_UNIT_MACROS_SVH
`define TEXT_LINE_FIT_TRUNCATE_WRAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlf assertion failed");

// Next-cycle implication, disabled during reset.
`define TLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlf assertion failed");

`endif

// ===== sv/tlf_pkg.sv =====
// Shared types, constants and codes of the line fitting unit.
// Depends on nothing; every other file but the macro header imports it.
package tlf_pkg;

  localparam int COL_W = 10;
  localparam int TAB_W = 7;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam int MAX_WIDTH = 1023;
  localparam int MAX_TAB = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  localparam logic [COL_W-1:0] RESET_WIDTH = 10'd80;
  localparam logic [TAB_W-1:0] RESET_TAB = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_TABS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LINES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LINES = 3'd4;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_NL = 2'd1;
  localparam logic [1:0] KIND_TAB = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              file_start;
    logic [1:0]        kind;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] line_width;
    logic [TAB_W-1:0] tab_size;
    logic             convert_tabs;
    logic             pad_lines;
    logic             wrap_lines;
  } cfg_t;

endpackage

// ===== sv/tlf_ifs.sv =====
// Channel interfaces of the line fitting unit: input bytes, output runs
// and configuration writes. Depends on tlf_pkg.
interface tlf_in_if import tlf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

interface tlf_out_if import tlf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [COL_W-1:0]  repeat_count;
  logic              last_of_run;

  modport source (output valid, output out_byte, output repeat_count,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input repeat_count,
                input last_of_run, output ready);
endinterface

interface tlf_cfg_if import tlf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/tlf_front.sv =====
// Front end: accepts input requests and tags each byte with its kind.
// Depends on tlf_pkg and tlf_ifs.
module tlf_front import tlf_pkg::*; (
  tlf_in_if.sink src,
  input  logic   full,
  output logic   push,
  output item_t  push_item
);

  assign src.ready = !full;
  assign push = src.valid && !full;

  always_comb begin
    push_item.in_byte = src.in_byte;
    push_item.file_start = src.file_start;
    if (src.in_byte == CH_NL) begin
      push_item.kind = KIND_NL;
    end else if (src.in_byte == CH_TAB) begin
      push_item.kind = KIND_TAB;
    end else begin
      push_item.kind = KIND_CHAR;
    end
  end

endmodule

// ===== sv/tlf_queue.sv =====
// Short FIFO of classified bytes between the front end and the back end.
// Depends on tlf_pkg and the assertion macro header.
`include "text_line_fit_truncate_wrap_unit_macros.svh"

module tlf_queue import tlf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TLF_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, count != '0)
  `TLF_ASSERT_NOW(a_no_push_full, clk, rst, push, !full || pop)
  `TLF_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, count != '0)

endmodule

// ===== sv/tlf_rem.sv =====
// Restoring remainder unit: column modulo tab size, one dividend bit a cycle.
// Depends on tlf_pkg.
module tlf_rem import tlf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [COL_W-1:0] dividend,
  input  logic [TAB_W-1:0] divisor,
  output logic             busy,
  output logic [TAB_W-1:0] rem
);

  localparam int CNT_W = $clog2(COL_W);

  logic [COL_W-1:0] dvd;
  logic [TAB_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [TAB_W:0]   trial;

  assign trial = {rem, dvd[COL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(COL_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The partial remainder stays below the divisor, so both arms fit.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      d <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[COL_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        rem <= TAB_W'(trial - {1'b0, d});
      end else begin
        rem <= trial[TAB_W-1:0];
      end
    end
  end

endmodule

// ===== sv/tlf_back.sv =====
// Back end: keeps the column, fits bytes to the line and drives the
// output register. Depends on tlf_pkg, tlf_ifs, tlf_rem and the macro header.
`include "text_line_fit_truncate_wrap_unit_macros.svh"

module tlf_back import tlf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_valid,
  input  item_t  q_item,
  output logic   q_pop,
  tlf_out_if.source dst
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_EMIT2 = 2'd2;

  logic [1:0]        state, state_next;
  logic [COL_W-1:0]  column, column_next;
  logic [BYTE_W-1:0] pend_byte, pend_next;

  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic [COL_W-1:0]  o_count;
  logic              o_last;

  logic              emit;
  logic [BYTE_W-1:0] e_byte;
  logic [COL_W-1:0]  e_count;
  logic              e_last;

  logic [COL_W-1:0]  w_eff;
  logic [TAB_W-1:0]  t_eff;
  logic              out_free;
  logic [COL_W-1:0]  col0;

  logic              rem_start;
  logic              rem_busy;
  logic [TAB_W-1:0]  rem_val;

  logic [COL_W-1:0]  tcol;
  logic [TAB_W-1:0]  trem;
  logic [TAB_W-1:0]  tq;
  logic [COL_W-1:0]  room;
  logic [COL_W-1:0]  tab_n;
  logic [COL_W:0]    tab_sum;
  logic [COL_W-1:0]  tab_col;
  logic [BYTE_W-1:0] tab_byte;
  logic [COL_W-1:0]  tab_count;

  tlf_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (col0),
    .divisor  (t_eff),
    .busy     (rem_busy),
    .rem      (rem_val)
  );

  always_comb begin
    if (cfg.line_width == '0) begin
      w_eff = COL_W'(1);
    end else if (cfg.line_width > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.line_width;
    end
    if (cfg.tab_size == '0) begin
      t_eff = TAB_W'(1);
    end else if (cfg.tab_size > TAB_W'(MAX_TAB)) begin
      t_eff = TAB_W'(MAX_TAB);
    end else begin
      t_eff = cfg.tab_size;
    end
  end

  assign out_free = !o_valid || dst.ready;
  assign col0 = q_item.file_start ? '0 : column;

  // Tab result, shared by the short path (column below the tab size, where
  // the column is its own remainder) and the path through the divider.
  always_comb begin
    tcol = (state == ST_DIV) ? column : col0;
    trem = (state == ST_DIV) ? rem_val : col0[TAB_W-1:0];
    tq = t_eff - trem;
    room = w_eff - tcol;
    tab_n = ({{(COL_W-TAB_W){1'b0}}, tq} < room) ? {{(COL_W-TAB_W){1'b0}}, tq} : room;
    tab_sum = {1'b0, tcol} + {{(COL_W+1-TAB_W){1'b0}}, tq};
    tab_col = (tab_sum > {1'b0, w_eff}) ? w_eff : tab_sum[COL_W-1:0];
    tab_byte = cfg.convert_tabs ? CH_SPACE : CH_TAB;
    tab_count = cfg.convert_tabs ? tab_n : COL_W'(1);
  end

  always_comb begin
    q_pop = 1'b0;
    emit = 1'b0;
    e_byte = CH_NL;
    e_count = COL_W'(1);
    e_last = 1'b1;
    column_next = column;
    state_next = state;
    pend_next = pend_byte;
    rem_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          column_next = col0;
          unique case (q_item.kind)
            KIND_NL: begin
              emit = 1'b1;
              column_next = '0;
              if (cfg.pad_lines && (col0 < w_eff)) begin
                e_byte = CH_SPACE;
                e_count = w_eff - col0;
                e_last = 1'b0;
                pend_next = CH_NL;
                state_next = ST_EMIT2;
              end
            end
            KIND_TAB: begin
              if (col0 < w_eff) begin
                if (col0 < {{(COL_W-TAB_W){1'b0}}, t_eff}) begin
                  emit = 1'b1;
                  e_byte = tab_byte;
                  e_count = tab_count;
                  column_next = tab_col;
                end else begin
                  rem_start = 1'b1;
                  state_next = ST_DIV;
                end
              end else if (cfg.wrap_lines) begin
                emit = 1'b1;
                column_next = '0;
              end
            end
            KIND_CHAR: begin
              if (col0 < w_eff) begin
                emit = 1'b1;
                e_byte = q_item.in_byte;
                column_next = col0 + 1'b1;
              end else if (cfg.wrap_lines) begin
                // Break the line, then place the byte at the head of the new one.
                emit = 1'b1;
                e_last = 1'b0;
                pend_next = q_item.in_byte;
                column_next = COL_W'(1);
                state_next = ST_EMIT2;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (!rem_busy && out_free) begin
          emit = 1'b1;
          e_byte = tab_byte;
          e_count = tab_count;
          column_next = tab_col;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          emit = 1'b1;
          e_byte = pend_byte;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      column <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      column <= column_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (dst.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_next;
    if (emit) begin
      o_byte <= e_byte;
      o_count <= e_count;
      o_last <= e_last;
    end
  end

  assign dst.valid = o_valid;
  assign dst.out_byte = o_byte;
  assign dst.repeat_count = o_count;
  assign dst.last_of_run = o_last;

  `TLF_ASSERT_NOW(a_emit2_has_first, clk, rst, state == ST_EMIT2, o_valid && !o_last)
  `TLF_ASSERT_NOW(a_count_nonzero, clk, rst, o_valid, o_count != '0)
  `TLF_ASSERT_NOW(a_pop_only_idle, clk, rst, q_pop, state == ST_IDLE)
  `TLF_ASSERT_NEXT(a_div_runs, clk, rst, rem_start, rem_busy && state == ST_DIV)

endmodule

// ===== sv/text_line_fit_truncate_wrap_unit.sv =====
// Channel  Dir  Modport       Payload
// src      in   tlf_in_if     in_byte[7:0], file_start
// dst      out  tlf_out_if    out_byte[7:0], repeat_count[9:0], last_of_run
// cfg      in   tlf_cfg_if    index[2:0], data[9:0]; always ready
//
// A fitting plain byte, or a tab whose column is below the tab size, is handled
// in the idle state and gives one output run; a padded newline or a wrapped
// byte gives two output runs. A tab at a column of at least the tab size runs
// the remainder unit, one dividend bit a cycle, before its run goes out.
// Reset is synchronous and clears the column, the queue and the registers to
// their defaults. A stalled output holds its register; the queue keeps
// accepting until it is full.
// Top level of the line fitting unit. Depends on tlf_pkg, tlf_ifs, tlf_front,
// tlf_queue and tlf_back.
module text_line_fit_truncate_wrap_unit import tlf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  tlf_in_if.sink     src,
  tlf_out_if.source  dst,
  tlf_cfg_if.sink    cfg
);

  cfg_t  regs;
  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  logic  head_valid;
  item_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.line_width <= RESET_WIDTH;
      regs.tab_size <= RESET_TAB;
      regs.convert_tabs <= 1'b0;
      regs.pad_lines <= 1'b0;
      regs.wrap_lines <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LINE_WIDTH:   regs.line_width <= cfg.data[COL_W-1:0];
        CFG_TAB_SIZE:     regs.tab_size <= cfg.data[TAB_W-1:0];
        CFG_CONVERT_TABS: regs.convert_tabs <= cfg.data[0];
        CFG_PAD_LINES:    regs.pad_lines <= cfg.data[0];
        CFG_WRAP_LINES:   regs.wrap_lines <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  tlf_front u_front (
    .src       (src),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  tlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tlf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (head_valid),
    .q_item  (head),
    .q_pop   (pop),
    .dst     (dst)
  );

endmodule

// ===== dv/tlf_line_fit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the line fitting unit. It follows register writes and accepted
// requests, predicts the output runs and compares each accepted run.
// Depends on tlf_pkg and the channel interfaces in tlf_ifs.
module tlf_line_fit_checker import tlf_pkg::*; (
  input  logic clk,
  input  logic rst,
  tlf_in_if    src,
  tlf_out_if   dst,
  tlf_cfg_if   cfg,
  output int   fail_count,
  output int   runs_pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] chr;
    logic [COL_W-1:0]  count;
    logic              last;
  } run_t;

  run_t runs_due[$];
  cfg_t regs;
  int   cur_col;

  task automatic report_mismatch(input string what);
    $display("%0t ERROR: %s", $time, what);
    fail_count++;
  endtask

  function automatic void push_run(input logic [BYTE_W-1:0] chr, input int count,
                                   input logic last);
    run_t r;
    r.chr = chr;
    r.count = count[COL_W-1:0];
    r.last = last;
    runs_due.push_back(r);
  endfunction

  // Works out the runs one request causes and moves the column along.
  function automatic void fit_byte(input logic [BYTE_W-1:0] chr, input logic fresh_file);
    int w, t, col, step, n;
    w = int'(regs.line_width);
    t = int'(regs.tab_size);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (t < 1) t = 1;
    if (t > MAX_TAB) t = MAX_TAB;
    col = fresh_file ? 0 : cur_col;

    if (chr == CH_NL) begin
      if (regs.pad_lines && col < w) push_run(CH_SPACE, w - col, 1'b0);
      push_run(CH_NL, 1, 1'b1);
      col = 0;
    end else if (chr == CH_TAB) begin
      if (col < w) begin
        step = t - (col % t);
        if (regs.convert_tabs) begin
          n = (step < w - col) ? step : w - col;
          push_run(CH_SPACE, n, 1'b1);
        end else begin
          push_run(CH_TAB, 1, 1'b1);
        end
        col = (col + step > w) ? w : col + step;
      end else if (regs.wrap_lines) begin
        // A tab that runs past the width only breaks the line.
        push_run(CH_NL, 1, 1'b1);
        col = 0;
      end
    end else begin
      if (col < w) begin
        push_run(chr, 1, 1'b1);
        col++;
      end else if (regs.wrap_lines) begin
        push_run(CH_NL, 1, 1'b0);
        push_run(chr, 1, 1'b1);
        col = 1;
      end
    end
    cur_col = col;
  endfunction

  always @(posedge clk) begin
    run_t want;
    if (rst) begin
      regs.line_width = RESET_WIDTH;
      regs.tab_size = RESET_TAB;
      regs.convert_tabs = 1'b0;
      regs.pad_lines = 1'b0;
      regs.wrap_lines = 1'b0;
      cur_col = 0;
      runs_due.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_LINE_WIDTH: regs.line_width = cfg.data[COL_W-1:0];
          CFG_TAB_SIZE: regs.tab_size = cfg.data[TAB_W-1:0];
          CFG_CONVERT_TABS: regs.convert_tabs = cfg.data[0];
          CFG_PAD_LINES: regs.pad_lines = cfg.data[0];
          CFG_WRAP_LINES: regs.wrap_lines = cfg.data[0];
          default: ;
        endcase
      end
      // Runs out now belong to older requests, so compare before predicting.
      if (dst.valid && dst.ready) begin
        if (runs_due.size() == 0) begin
          report_mismatch($sformatf("run %h x%0d arrived with nothing expected",
                                    dst.out_byte, dst.repeat_count));
        end else begin
          want = runs_due.pop_front();
          if (dst.out_byte !== want.chr)
            report_mismatch($sformatf("out_byte %h, expected %h", dst.out_byte, want.chr));
          if (dst.repeat_count !== want.count)
            report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                      dst.repeat_count, want.count));
          if (dst.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      dst.last_of_run, want.last));
        end
      end
      if (src.valid && src.ready) fit_byte(src.in_byte, src.file_start);
    end
    runs_pending = runs_due.size();
  end

endmodule

// ===== dv/tb_text_line_fit_truncate_wrap_unit.sv =====
`timescale 1ns / 1ps
// Testbench top of the line fitting unit: clock, reset, register writes, text
// stimulus and a randomly stalling receiver. Depends on tlf_pkg, tlf_ifs, the
// unit itself and tlf_line_fit_checker, which does all the comparing.
module tb_text_line_fit_truncate_wrap_unit;
  import tlf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   runs_pending;
  bit   src_calm;
  bit   dst_calm;

  tlf_in_if  src_ch ();
  tlf_out_if dst_ch ();
  tlf_cfg_if cfg_ch ();

  text_line_fit_truncate_wrap_unit DUT (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .dst (dst_ch),
    .cfg (cfg_ch)
  );

  tlf_line_fit_checker chk (
    .clk          (clk),
    .rst          (rst),
    .src          (src_ch),
    .dst          (dst_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .runs_pending (runs_pending)
  );

  always #2 clk = ~clk;

  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

  // Each task below starts and ends at a falling edge, so valid is never
  // assigned twice in one time step.
  task automatic send_char(input logic [BYTE_W-1:0] chr, input logic fresh_file);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_ch.valid <= 1'b1;
    src_ch.in_byte <= chr;
    src_ch.file_start <= fresh_file;
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle(input int settle);
    src_ch.valid <= 1'b0;
    do @(negedge clk); while (runs_pending != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Upper data bits beyond each register's width are random on purpose.
  task automatic apply_setting(input int w, input int t, input logic conv,
                               input logic pad, input logic wrap, input logic poke);
    logic [CFG_DATA_W-1:0] d;
    wait_idle(60);
    write_reg(CFG_LINE_WIDTH, w[CFG_DATA_W-1:0]);
    d = CFG_DATA_W'($urandom);
    d[TAB_W-1:0] = t[TAB_W-1:0];
    write_reg(CFG_TAB_SIZE, d);
    d = CFG_DATA_W'($urandom);
    d[0] = conv;
    write_reg(CFG_CONVERT_TABS, d);
    d = CFG_DATA_W'($urandom);
    d[0] = pad;
    write_reg(CFG_PAD_LINES, d);
    d = CFG_DATA_W'($urandom);
    d[0] = wrap;
    write_reg(CFG_WRAP_LINES, d);
    if (poke) begin
      // Indexes past the last register must leave every setting alone.
      write_reg(CFG_WRAP_LINES + 3'd1, '1);
      write_reg('1, CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return BYTE_W'($urandom_range(8'h21, 8'h7E));
    if (r < 72) return CH_SPACE;
    if (r < 85) return CH_TAB;
    if (r < 88) return CH_NL;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Sends whole lines of up to 2*w+2 bytes, at most 48, so that short and, for
  // narrow widths, overlong lines occur; pause_mid lets the output drain midway.
  task automatic run_phase(input int w, input int items, input bit pause_mid);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(0, (2 * w + 2 < 48) ? 2 * w + 2 : 48);
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(), $urandom_range(0, 24) == 0);
      end
      send_char(CH_NL, $urandom_range(0, 24) == 0);
      sent += len + 1;
      if (pause_mid && sent >= items / 2 && sent - len - 1 < items / 2) wait_idle(0);
    end
  endtask

  initial begin
    int res_cnt;
    dst_ch.ready = 1'b0;
    res_cnt = 0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      int gap;
      if (res_cnt % 40 == 0) dst_calm = ($urandom_range(0, 3) == 0);
      gap = dst_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        dst_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      dst_ch.ready <= 1'b1;
      @(posedge clk);
      while (!dst_ch.valid) @(posedge clk);
      res_cnt++;
      @(negedge clk);
    end
  end

  initial begin
    int w, t;
    src_ch.valid = 1'b0;
    src_ch.in_byte = '0;
    src_ch.file_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    src_calm = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: extreme byte values, a file start and a plain tab.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(CH_TAB, 1'b0);
    send_char("a", 1'b0);
    send_char(CH_NL, 1'b0);

    // Narrow line with every mode on: clipped tab, wrapped byte, padded
    // newline and a wrapped tab.
    apply_setting(3, 2, 1'b1, 1'b1, 1'b1, 1'b1);
    send_char("x", 1'b0);
    send_char("y", 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char("z", 1'b0);
    send_char(CH_NL, 1'b0);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    send_char(CH_TAB, 1'b0);

    // Width lowered below the current column: the byte and tab before the newline
    // drop and the newline gets no padding.
    apply_setting(80, MAX_TAB, 1'b0, 1'b1, 1'b0, 1'b0);
    send_char("p", 1'b0);
    send_char("q", 1'b0);
    send_char("r", 1'b0);
    apply_setting(2, 1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_char("s", 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(8'h7F, 1'b0);

    // Widest line: padding runs up to the full width.
    apply_setting(MAX_WIDTH, 1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_NL, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0: w = 1;
        1: w = MAX_WIDTH;
        2, 3: w = $urandom_range(2, 12);
        4: w = $urandom_range(13, 100);
        default: w = $urandom_range(1, MAX_WIDTH);
      endcase
      case ($urandom_range(0, 3))
        0: t = 1;
        1: t = MAX_TAB;
        2: t = $urandom_range(2, 8);
        default: t = $urandom_range(2, MAX_TAB);
      endcase
      if (ph == 0) begin
        w = MAX_WIDTH;
        t = MAX_TAB;
      end
      if (ph == 1) begin
        w = 1;
        t = 1;
      end
      src_calm = ($urandom_range(0, 3) == 0);
      apply_setting(w, t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0);
      run_phase(w, 95, ph == 5);
    end

    wait_idle(60);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
